>>> rtl/prq_pkg.sv
// Shared types and codes for the process ready queue.
package prq_pkg;

    localparam int SLOT_W     = 6;
    localparam int PID_W      = 31;
    localparam int PRIO_W     = 4;
    localparam int LEVEL_W    = 7;
    localparam int QUANTUM_W  = 8;
    localparam int COUNT_W    = 7;
    localparam int STATUS_W   = 2;
    localparam int KIND_W     = 3;
    // number of slot ids the slot field can name
    localparam int SLOT_IDS   = 1 << SLOT_W;

    typedef logic [KIND_W-1:0]    t_kind;
    typedef logic [SLOT_W-1:0]    t_slot;
    typedef logic [PID_W-1:0]     t_pid;
    typedef logic [PRIO_W-1:0]    t_prio;
    typedef logic [LEVEL_W-1:0]   t_level;
    typedef logic [QUANTUM_W-1:0] t_quantum;
    typedef logic [COUNT_W-1:0]   t_count;
    typedef logic [STATUS_W-1:0]  t_status;

    localparam t_kind KIND_PUSH   = 3'd0;
    localparam t_kind KIND_POP    = 3'd1;
    localparam t_kind KIND_REMOVE = 3'd2;
    localparam t_kind KIND_TOP    = 3'd3;
    localparam t_kind KIND_ROTATE = 3'd4;
    localparam t_kind KIND_EXISTS = 3'd5;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_EMPTY     = 2'd1;
    localparam t_status ST_NOT_FOUND = 2'd2;

    // level at and above which the queue runs in special mode
    localparam t_level   SPECIAL_LEVEL   = 7'd99;
    localparam t_quantum SPECIAL_QUANTUM = 8'd99;

    // per-slot payload kept in the entry memory
    typedef struct packed {
        t_pid  pid;
        t_prio prio;
    } t_entry;

    // result of one request, handed from the controller to the output stage
    typedef struct packed {
        t_status status;
        t_slot   slot;
        t_pid    pid;
        t_count  count;
    } t_result;

endpackage

>>> rtl/process_ready_queue_priority_pop_top.sv
// Top level of the process ready queue: level register, controller, memories, output stage.
// Push onto an empty queue, refresh, empty-queue and rejected requests go from start
// straight to commit; a linking push passes a link step; pop front, remove by pid, top pop,
// rotate and exists walk the list, the last four over every queued entry, one link read
// per cycle. One request in work at a time: no new beat is taken until the result
// registers. Sync reset empties the queue, zeroes the level, drops the output.
module process_ready_queue_priority_pop_top #(
    parameter int SLOTS        = 64,
    parameter int TOP_PRIORITY = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_cfg_wr_en,
    input  prq_pkg::t_level           i_cfg_wr_data,
    // request channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  prq_pkg::t_kind            i_kind,
    input  prq_pkg::t_slot            i_slot,
    input  prq_pkg::t_pid             i_proc_id,
    input  prq_pkg::t_prio            i_prio,
    // result channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output prq_pkg::t_status          o_status,
    output prq_pkg::t_slot            o_out_slot,
    output prq_pkg::t_pid             o_out_proc_id,
    output prq_pkg::t_level           o_assigned_level,
    output prq_pkg::t_quantum         o_quantum,
    output prq_pkg::t_count           o_count
);

    localparam int IW = $clog2(SLOTS);

    prq_pkg::t_level   r_level;
    logic              r_out_valid;
    prq_pkg::t_result  r_out;
    prq_pkg::t_level   r_out_level;
    prq_pkg::t_quantum r_out_quantum;

    prq_pkg::t_level   eff_level;
    prq_pkg::t_quantum quantum;
    logic              out_free;
    logic              commit;
    prq_pkg::t_result  result;

    logic [IW-1:0]     rd_addr;
    logic [IW-1:0]     rd_next;
    prq_pkg::t_entry   rd_entry;
    logic              nx_we;
    logic [IW-1:0]     nx_addr;
    logic [IW-1:0]     nx_data;
    logic              en_we;
    logic [IW-1:0]     en_addr;
    prq_pkg::t_entry   en_data;

    // queue level; to be written only while no request is in work, not enforced by the block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else if (i_cfg_wr_en) begin
            r_level <= i_cfg_wr_data;
        end
    end

    // levels above the special one act as the special one
    assign eff_level = (r_level > prq_pkg::SPECIAL_LEVEL) ? prq_pkg::SPECIAL_LEVEL : r_level;
    // quantum is twice (level + 1), except in special mode
    assign quantum = (eff_level == prq_pkg::SPECIAL_LEVEL)
                     ? prq_pkg::SPECIAL_QUANTUM
                     : prq_pkg::t_quantum'(
                           (prq_pkg::t_quantum'(eff_level) + prq_pkg::t_quantum'(1)) << 1);

    // output register frees when empty or when its beat is taken this cycle,
    // so the controller can commit a new result in the cycle the waiting one is taken
    assign out_free = !r_out_valid || !i_out_stall;

    prq_ctrl #(
        .SLOTS        (SLOTS),
        .TOP_PRIORITY (TOP_PRIORITY)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_kind     (i_kind),
        .i_slot     (i_slot),
        .i_proc_id  (i_proc_id),
        .i_prio     (i_prio),
        .i_out_free (out_free),
        .o_commit   (commit),
        .o_result   (result),
        .o_rd_addr  (rd_addr),
        .i_rd_next  (rd_next),
        .i_rd_entry (rd_entry),
        .o_nx_we    (nx_we),
        .o_nx_addr  (nx_addr),
        .o_nx_data  (nx_data),
        .o_en_we    (en_we),
        .o_en_addr  (en_addr),
        .o_en_data  (en_data)
    );

    prq_store #(
        .SLOTS (SLOTS)
    ) u_store (
        .i_clk      (i_clk),
        .i_rd_addr  (rd_addr),
        .o_rd_next  (rd_next),
        .o_rd_entry (rd_entry),
        .i_nx_we    (nx_we),
        .i_nx_addr  (nx_addr),
        .i_nx_data  (nx_data),
        .i_en_we    (en_we),
        .i_en_addr  (en_addr),
        .i_en_data  (en_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out         <= result;
            r_out_level   <= eff_level;
            r_out_quantum <= quantum;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out.status;
    assign o_out_slot       = r_out.slot;
    assign o_out_proc_id    = r_out.pid;
    assign o_count          = r_out.count;
    assign o_assigned_level = r_out_level;
    assign o_quantum        = r_out_quantum;

endmodule

>>> rtl/prq_store.sv
// Link and entry memories of the ready queue, one read and one write port each.
module prq_store #(
    parameter int SLOTS = 64
) (
    input  logic                      i_clk,
    input  logic [$clog2(SLOTS)-1:0]  i_rd_addr,
    output logic [$clog2(SLOTS)-1:0]  o_rd_next,
    output prq_pkg::t_entry           o_rd_entry,
    input  logic                      i_nx_we,
    input  logic [$clog2(SLOTS)-1:0]  i_nx_addr,
    input  logic [$clog2(SLOTS)-1:0]  i_nx_data,
    input  logic                      i_en_we,
    input  logic [$clog2(SLOTS)-1:0]  i_en_addr,
    input  prq_pkg::t_entry           i_en_data
);

    localparam int IW = $clog2(SLOTS);

    logic [IW-1:0]   r_next_mem  [SLOTS];
    prq_pkg::t_entry r_entry_mem [SLOTS];
    logic [IW-1:0]   r_rd_next;
    prq_pkg::t_entry r_rd_entry;

    always_ff @(posedge i_clk) begin
        if (i_nx_we) begin
            r_next_mem[i_nx_addr] <= i_nx_data;
        end
        r_rd_next <= r_next_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_en_we) begin
            r_entry_mem[i_en_addr] <= i_en_data;
        end
        r_rd_entry <= r_entry_mem[i_rd_addr];
    end

    assign o_rd_next  = r_rd_next;
    assign o_rd_entry = r_rd_entry;

endmodule

>>> rtl/prq_ctrl.sv
// Request sequencer of the ready queue: decode, list walk and commit.
module prq_ctrl #(
    parameter int SLOTS        = 64,
    parameter int TOP_PRIORITY = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // request channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  prq_pkg::t_kind            i_kind,
    input  prq_pkg::t_slot            i_slot,
    input  prq_pkg::t_pid             i_proc_id,
    input  prq_pkg::t_prio            i_prio,
    // result hand-off
    input  logic                      i_out_free,
    output logic                      o_commit,
    output prq_pkg::t_result          o_result,
    // memory ports
    output logic [$clog2(SLOTS)-1:0]  o_rd_addr,
    input  logic [$clog2(SLOTS)-1:0]  i_rd_next,
    input  prq_pkg::t_entry           i_rd_entry,
    output logic                      o_nx_we,
    output logic [$clog2(SLOTS)-1:0]  o_nx_addr,
    output logic [$clog2(SLOTS)-1:0]  o_nx_data,
    output logic                      o_en_we,
    output logic [$clog2(SLOTS)-1:0]  o_en_addr,
    output prq_pkg::t_entry           o_en_data
);

    localparam int IW = $clog2(SLOTS);
    typedef logic [IW-1:0] t_idx;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_START  = 3'd1;
    localparam logic [2:0] S_WALK   = 3'd2;
    localparam logic [2:0] S_LINK   = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;

    localparam prq_pkg::t_prio PRIO_CAP = prq_pkg::t_prio'(TOP_PRIORITY);

    // control state
    logic [2:0]                   r_state;
    t_idx                         r_head;
    t_idx                         r_tail;
    prq_pkg::t_count              r_occ;
    logic [prq_pkg::SLOT_IDS-1:0] r_present;

    // request and walk registers
    prq_pkg::t_kind   r_kind;
    prq_pkg::t_slot   r_slot;
    prq_pkg::t_pid    r_pid;
    prq_pkg::t_prio   r_prio;
    t_idx             r_cur;
    t_idx             r_prev;
    t_idx             r_best;
    t_idx             r_bprev;
    t_idx             r_bnx;
    prq_pkg::t_prio   r_bprio;
    prq_pkg::t_count  r_i;
    logic             r_hit;
    logic             r_walk;
    logic             r_link;
    prq_pkg::t_status r_status;
    prq_pkg::t_slot   r_oslot;
    prq_pkg::t_pid    r_opid;

    logic             in_acc;
    logic             slot_ok;
    t_idx             slot_idx;
    logic             pres;
    logic             occ_zero;
    logic             take;
    logic             walk_last;
    logic             unlink;
    logic             rotate;
    prq_pkg::t_count  n_occ;
    t_idx             n_head;
    t_idx             n_tail;
    prq_pkg::t_status res_status;

    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    assign slot_ok  = (int'(r_slot) < SLOTS);
    assign slot_idx = t_idx'(r_slot);
    assign pres     = slot_ok && r_present[r_slot];
    assign occ_zero = (r_occ == '0);

    // selection rule of the walk, evaluated on the entry read for r_cur
    always_comb begin
        unique case (r_kind) inside
            prq_pkg::KIND_POP:    take = !r_hit;
            prq_pkg::KIND_REMOVE: take = !r_hit && (i_rd_entry.pid == r_pid);
            prq_pkg::KIND_TOP:    take = !r_hit || (i_rd_entry.prio > r_bprio);
            prq_pkg::KIND_ROTATE,
            prq_pkg::KIND_EXISTS: take = !r_hit && (r_cur == slot_idx);
            default:              take = 1'b0;
        endcase
    end

    assign walk_last = (r_kind == prq_pkg::KIND_POP)
                       || (r_i == (r_occ - prq_pkg::t_count'(1)));

    assign unlink = r_walk && r_hit
                    && ((r_kind == prq_pkg::KIND_POP) || (r_kind == prq_pkg::KIND_REMOVE)
                        || (r_kind == prq_pkg::KIND_TOP));
    assign rotate = r_walk && r_hit && (r_kind == prq_pkg::KIND_ROTATE);

    always_comb begin
        n_occ  = r_occ;
        n_head = r_head;
        n_tail = r_tail;
        if (r_link) begin
            n_occ = r_occ + prq_pkg::t_count'(1);
            if (occ_zero) begin
                n_head = slot_idx;
            end
            n_tail = slot_idx;
        end
        if (unlink) begin
            n_occ = r_occ - prq_pkg::t_count'(1);
            if (r_best == r_head) begin
                n_head = r_bnx;
            end
            if (r_best == r_tail) begin
                n_tail = r_bprev;
            end
            if (n_occ == '0) begin
                n_head = '0;
                n_tail = '0;
            end
        end
        if (rotate) begin
            n_head = r_best;
            n_tail = r_bprev;
        end
    end

    assign res_status = (r_walk && !r_hit) ? prq_pkg::ST_NOT_FOUND : r_status;

    assign o_commit = (r_state == S_COMMIT) && i_out_free;
    assign o_result = '{status: res_status, slot: r_oslot, pid: r_opid, count: n_occ};

    // memory port steering; reads chase the link read in the previous cycle
    always_comb begin
        o_rd_addr = (r_state == S_WALK) ? i_rd_next : r_head;
        o_nx_we   = 1'b0;
        o_nx_addr = r_tail;
        o_nx_data = slot_idx;
        o_en_we   = 1'b0;
        o_en_addr = slot_idx;
        o_en_data = '{pid: r_pid, prio: r_prio};
        if ((r_state == S_START) && (r_kind == prq_pkg::KIND_PUSH) && slot_ok) begin
            o_en_we = 1'b1;
            if (!pres) begin
                o_nx_we   = 1'b1;
                o_nx_addr = occ_zero ? slot_idx : r_tail;
            end
        end
        if (r_state == S_LINK) begin
            o_nx_we   = 1'b1;
            o_nx_addr = slot_idx;
            o_nx_data = r_head;
        end
        if (o_commit && unlink) begin
            o_nx_we   = 1'b1;
            o_nx_addr = r_bprev;
            o_nx_data = r_bnx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_tail    <= '0;
            r_occ     <= '0;
            r_present <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    unique case (r_kind) inside
                        prq_pkg::KIND_PUSH: begin
                            r_state <= (slot_ok && !pres && !occ_zero) ? S_LINK : S_COMMIT;
                        end
                        prq_pkg::KIND_POP, prq_pkg::KIND_REMOVE, prq_pkg::KIND_TOP: begin
                            r_state <= occ_zero ? S_COMMIT : S_WALK;
                        end
                        prq_pkg::KIND_ROTATE, prq_pkg::KIND_EXISTS: begin
                            r_state <= (occ_zero || !pres) ? S_COMMIT : S_WALK;
                        end
                        default: begin
                            r_state <= S_COMMIT;
                        end
                    endcase
                end
                S_WALK: begin
                    if (walk_last) begin
                        r_state <= S_COMMIT;
                    end
                end
                S_LINK: begin
                    r_state <= S_COMMIT;
                end
                S_COMMIT: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                        r_occ   <= n_occ;
                        r_head  <= n_head;
                        r_tail  <= n_tail;
                        if (r_link) begin
                            r_present[r_slot] <= 1'b1;
                        end
                        if (unlink) begin
                            r_present[prq_pkg::t_slot'(r_best)] <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_kind <= i_kind;
                    r_slot <= i_slot;
                    r_pid  <= i_proc_id;
                    r_prio <= (i_prio > PRIO_CAP) ? PRIO_CAP : i_prio;
                end
            end
            S_START: begin
                r_status <= prq_pkg::ST_OK;
                r_oslot  <= '0;
                r_opid   <= '0;
                r_hit    <= 1'b0;
                r_walk   <= 1'b0;
                r_link   <= 1'b0;
                r_cur    <= r_head;
                r_prev   <= r_tail;
                r_i      <= '0;
                r_bprio  <= '0;
                unique case (r_kind) inside
                    prq_pkg::KIND_PUSH: begin
                        if (!slot_ok) begin
                            r_status <= prq_pkg::ST_NOT_FOUND;
                        end else begin
                            r_oslot <= r_slot;
                            r_opid  <= r_pid;
                            r_link  <= !pres;
                        end
                    end
                    prq_pkg::KIND_POP, prq_pkg::KIND_REMOVE, prq_pkg::KIND_TOP: begin
                        if (occ_zero) begin
                            r_status <= prq_pkg::ST_EMPTY;
                        end else begin
                            r_walk <= 1'b1;
                        end
                    end
                    prq_pkg::KIND_ROTATE, prq_pkg::KIND_EXISTS: begin
                        if (occ_zero) begin
                            r_status <= prq_pkg::ST_EMPTY;
                        end else if (!pres) begin
                            r_status <= prq_pkg::ST_NOT_FOUND;
                        end else begin
                            r_walk <= 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_WALK: begin
                if (take) begin
                    r_hit   <= 1'b1;
                    r_best  <= r_cur;
                    r_bprev <= r_prev;
                    r_bnx   <= i_rd_next;
                    r_bprio <= i_rd_entry.prio;
                    r_oslot <= prq_pkg::t_slot'(r_cur);
                    r_opid  <= i_rd_entry.pid;
                end
                r_prev <= r_cur;
                r_cur  <= i_rd_next;
                r_i    <= r_i + prq_pkg::t_count'(1);
            end
            default: begin
            end
        endcase
    end

    // presence bits and entry count move together
    a_occ_matches_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_present) == int'(r_occ))
        else $error("occupancy differs from number of queued slots");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ == '0) |-> ((r_head == '0) && (r_tail == '0)))
        else $error("empty queue with nonzero front or rear");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_i < r_occ))
        else $error("walk ran past the queued entries");

    a_slot_walk_hits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_COMMIT) && r_walk
         && ((r_kind == prq_pkg::KIND_ROTATE) || (r_kind == prq_pkg::KIND_EXISTS)))
        |-> r_hit)
        else $error("queued slot not met on the walk");

endmodule

>>> dv/process_ready_queue_priority_pop_top_test.sv
// Self-checking testbench for the process ready queue with priority pop.
`timescale 1ns / 1ps

module process_ready_queue_priority_pop_top_test;

    localparam int SLOT_COUNT = 64;
    localparam int TOP_PRIO   = 10;
    // longest stretch with no beat on either channel before the run is called hung
    localparam int IDLE_LIMIT = 4000;
    // receiver hold-off length and the result count at which it starts
    localparam int LONG_HOLD  = 500;
    localparam int HOLD_AT    = 150;

    // kind codes the block does not serve
    localparam prq_pkg::t_kind KIND_SPARE_LO = 3'd6;
    localparam prq_pkg::t_kind KIND_SPARE_HI = 3'd7;

    typedef struct packed {
        prq_pkg::t_kind kind;
        prq_pkg::t_slot slot;
        prq_pkg::t_pid  pid;
        prq_pkg::t_prio prio;
    } t_sched_req;

    typedef struct packed {
        prq_pkg::t_status  status;
        prq_pkg::t_slot    slot;
        prq_pkg::t_pid     pid;
        prq_pkg::t_level   level;
        prq_pkg::t_quantum quantum;
        prq_pkg::t_count   count;
    } t_sched_res;

    // ---------------------------------------------------------------- DUT ports
    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_cfg_wr_en    = 1'b0;
    prq_pkg::t_level   i_cfg_wr_data  = '0;
    logic              i_in_valid     = 1'b0;
    logic              o_in_stall;
    prq_pkg::t_kind    i_kind         = prq_pkg::KIND_PUSH;
    prq_pkg::t_slot    i_slot         = '0;
    prq_pkg::t_pid     i_proc_id      = '0;
    prq_pkg::t_prio    i_prio         = '0;
    logic              o_out_valid;
    logic              i_out_stall    = 1'b0;
    prq_pkg::t_status  o_status;
    prq_pkg::t_slot    o_out_slot;
    prq_pkg::t_pid     o_out_proc_id;
    prq_pkg::t_level   o_assigned_level;
    prq_pkg::t_quantum o_quantum;
    prq_pkg::t_count   o_count;

    process_ready_queue_priority_pop_top #(
        .SLOTS        (SLOT_COUNT),
        .TOP_PRIORITY (TOP_PRIO)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_kind           (i_kind),
        .i_slot           (i_slot),
        .i_proc_id        (i_proc_id),
        .i_prio           (i_prio),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_out_slot       (o_out_slot),
        .o_out_proc_id    (o_out_proc_id),
        .o_assigned_level (o_assigned_level),
        .o_quantum        (o_quantum),
        .o_count          (o_count)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------- shadow queue state
    // Circular order linked through rq_next; rq_in marks queued slots.
    prq_pkg::t_slot  rq_next [SLOT_COUNT];
    prq_pkg::t_pid   rq_pid  [SLOT_COUNT];
    prq_pkg::t_prio  rq_prio [SLOT_COUNT];
    logic            rq_in   [SLOT_COUNT];
    prq_pkg::t_slot  rq_head;
    prq_pkg::t_slot  rq_tail;
    prq_pkg::t_count rq_count;
    prq_pkg::t_level rq_level;

    t_sched_req request_backlog [$];   // items waiting for the driver
    t_sched_res pending_results [$];   // predicted results, oldest first
    t_sched_req cur_req;               // beat currently on the request port

    prq_pkg::t_pid pid_pool [16];
    logic   calm = 1'b0;               // phase with no idling on either side
    int     errors = 0;
    int     beats_in = 0;
    int     beats_out = 0;
    int     peak_count = 0;
    int     kind_seen [8];
    int     gap_left = 0;
    int     hold_left = 0;
    int     stall_left = 0;
    int     run_left = 0;
    logic   long_done = 1'b0;
    int     idle_cycles = 0;

    // drop cur from the order; prv is its predecessor
    task automatic sched_unlink(input prq_pkg::t_slot prv, input prq_pkg::t_slot cur);
        prq_pkg::t_slot nx;
        nx = rq_next[cur];
        rq_next[prv] = nx;
        if (cur == rq_head) rq_head = nx;
        if (cur == rq_tail) rq_tail = prv;
        rq_in[cur] = 1'b0;
        rq_count = rq_count - prq_pkg::t_count'(1);
        if (rq_count == 0) begin
            rq_head = '0;
            rq_tail = '0;
        end
    endtask

    // Serve one request against the shadow state and build its result.
    task automatic sched_serve(input t_sched_req r, output t_sched_res x);
        prq_pkg::t_prio  pr;
        prq_pkg::t_level lv;
        prq_pkg::t_slot  prv;
        prq_pkg::t_slot  cur;
        prq_pkg::t_slot  best;
        prq_pkg::t_slot  bprev;
        prq_pkg::t_prio  bprio;
        logic   hit;
        logic   take;
        int     i;
        pr = (r.prio > TOP_PRIO) ? prq_pkg::t_prio'(TOP_PRIO) : r.prio;
        lv = (rq_level > prq_pkg::SPECIAL_LEVEL) ? prq_pkg::SPECIAL_LEVEL : rq_level;
        x.status = prq_pkg::ST_OK;
        x.slot   = '0;
        x.pid    = '0;
        case (r.kind)
            prq_pkg::KIND_PUSH: begin
                rq_pid[r.slot]  = r.pid;
                rq_prio[r.slot] = pr;
                x.slot = r.slot;
                x.pid  = r.pid;
                // a queued slot is refreshed in place
                if (!rq_in[r.slot]) begin
                    if (rq_count == 0) begin
                        rq_head = r.slot;
                        rq_tail = r.slot;
                        rq_next[r.slot] = r.slot;
                    end else begin
                        rq_next[rq_tail] = r.slot;
                        rq_next[r.slot]  = rq_head;
                        rq_tail = r.slot;
                    end
                    rq_in[r.slot] = 1'b1;
                    rq_count = rq_count + prq_pkg::t_count'(1);
                end
            end
            prq_pkg::KIND_POP: begin
                if (rq_count == 0) begin
                    x.status = prq_pkg::ST_EMPTY;
                end else begin
                    x.slot = rq_head;
                    x.pid  = rq_pid[rq_head];
                    sched_unlink(rq_tail, rq_head);
                end
            end
            prq_pkg::KIND_REMOVE, prq_pkg::KIND_TOP: begin
                if (rq_count == 0) begin
                    x.status = prq_pkg::ST_EMPTY;
                end else begin
                    hit = 1'b0;
                    best = '0;
                    bprev = '0;
                    bprio = '0;
                    prv = rq_tail;
                    cur = rq_head;
                    for (i = 0; i < int'(rq_count); i++) begin
                        // first pid match, or strictly higher priority so ties keep the earliest
                        if (r.kind == prq_pkg::KIND_REMOVE) take = !hit && (rq_pid[cur] == r.pid);
                        else take = !hit || (rq_prio[cur] > bprio);
                        if (take) begin
                            hit = 1'b1;
                            best = cur;
                            bprev = prv;
                            bprio = rq_prio[cur];
                        end
                        prv = cur;
                        cur = rq_next[cur];
                    end
                    if (!hit) begin
                        x.status = prq_pkg::ST_NOT_FOUND;
                    end else begin
                        x.slot = best;
                        x.pid  = rq_pid[best];
                        sched_unlink(bprev, best);
                    end
                end
            end
            prq_pkg::KIND_ROTATE, prq_pkg::KIND_EXISTS: begin
                if (rq_count == 0) begin
                    x.status = prq_pkg::ST_EMPTY;
                end else if (!rq_in[r.slot]) begin
                    x.status = prq_pkg::ST_NOT_FOUND;
                end else begin
                    x.slot = r.slot;
                    x.pid  = rq_pid[r.slot];
                    if (r.kind == prq_pkg::KIND_ROTATE) begin
                        prv = rq_tail;
                        cur = rq_head;
                        for (i = 0; i < int'(rq_count) && cur != r.slot; i++) begin
                            prv = cur;
                            cur = rq_next[cur];
                        end
                        rq_head = r.slot;
                        rq_tail = prv;
                    end
                end
            end
            default: ;
        endcase
        x.level   = lv;
        x.quantum = (lv == prq_pkg::SPECIAL_LEVEL) ? prq_pkg::SPECIAL_QUANTUM
                                                   : prq_pkg::t_quantum'(2 * (int'(lv) + 1));
        x.count   = rq_count;
    endtask

    // gap before the next request: mostly none or short, now and then long
    function automatic int pick_gap();
        int w;
        w = $urandom_range(99);
        if (calm) return 0;
        if (w < 60) return 0;
        if (w < 90) return $urandom_range(3, 1);
        if (w < 98) return $urandom_range(12, 4);
        return $urandom_range(80, 30);
    endfunction

    // Random request; slots mostly come from the low span so hits are common,
    // pids mostly from a small pool so remove by pid finds something.
    function automatic t_sched_req make_req(input int span);
        t_sched_req r;
        int w;
        w = $urandom_range(99);
        if (w < 40)      r.kind = prq_pkg::KIND_PUSH;
        else if (w < 52) r.kind = prq_pkg::KIND_POP;
        else if (w < 62) r.kind = prq_pkg::KIND_REMOVE;
        else if (w < 74) r.kind = prq_pkg::KIND_TOP;
        else if (w < 84) r.kind = prq_pkg::KIND_ROTATE;
        else if (w < 96) r.kind = prq_pkg::KIND_EXISTS;
        else             r.kind = ($urandom_range(1) != 0) ? KIND_SPARE_LO : KIND_SPARE_HI;
        r.slot = ($urandom_range(9) == 0) ? prq_pkg::t_slot'($urandom_range(SLOT_COUNT - 1))
                                          : prq_pkg::t_slot'($urandom_range(span - 1));
        r.pid  = ($urandom_range(3) == 0) ? prq_pkg::t_pid'($urandom)
                                          : pid_pool[$urandom_range(15)];
        r.prio = prq_pkg::t_prio'($urandom_range(15));
        return r;
    endfunction

    task automatic queue_req(input prq_pkg::t_kind k, input prq_pkg::t_slot s,
                             input prq_pkg::t_pid p, input prq_pkg::t_prio pr);
        t_sched_req r;
        r.kind = k;
        r.slot = s;
        r.pid  = p;
        r.prio = pr;
        request_backlog.push_back(r);
    endtask

    task automatic queue_random(input int n, input int span);
        int i;
        for (i = 0; i < n; i++) request_backlog.push_back(make_req(span));
    endtask

    // sender pauses here until every predicted result has come back
    task automatic wait_idle();
        do @(negedge i_clk);
        while (request_backlog.size() != 0 || i_in_valid || pending_results.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    // level register write; only called with the block idle
    task automatic set_level(input prq_pkg::t_level v);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        rq_level = v;
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------ driver
    // Accepted beat is predicted on the edge it is taken; the next item (or a
    // gap) is launched on that same edge, so valid dips between items only for a gap.
    always @(posedge i_clk) begin : drive_requests
        t_sched_req nxt;
        t_sched_res want;
        logic       free;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            free = !i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                sched_serve(cur_req, want);
                pending_results.push_back(want);
                beats_in++;
                kind_seen[cur_req.kind]++;
                if (int'(rq_count) > peak_count) peak_count = int'(rq_count);
                free = 1'b1;
            end
            if (free) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (request_backlog.size() > 0) begin
                    nxt = request_backlog.pop_front();
                    cur_req = nxt;
                    i_kind     <= nxt.kind;
                    i_slot     <= nxt.slot;
                    i_proc_id  <= nxt.pid;
                    i_prio     <= nxt.prio;
                    i_in_valid <= 1'b1;
                    gap_left = pick_gap();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ----------------------------------------------------------------- monitor
    // Checks each result beat against the oldest prediction and plays the
    // receiver: random stalls, plus one long hold-off while the sender keeps
    // offering requests.
    always @(posedge i_clk) begin : watch_results
        t_sched_res seen;
        t_sched_res want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                seen.status  = o_status;
                seen.slot    = o_out_slot;
                seen.pid     = o_out_proc_id;
                seen.level   = o_assigned_level;
                seen.quantum = o_quantum;
                seen.count   = o_count;
                beats_out++;
                if (pending_results.size() == 0) begin
                    errors++;
                    $display("%0t: result beat with nothing expected: st=%0d slot=%0d pid=%0h",
                             $time, seen.status, seen.slot, seen.pid);
                end else begin
                    want = pending_results.pop_front();
                    if (seen !== want) begin
                        errors++;
                        $display("%0t: mismatch expected st=%0d slot=%0d pid=%0h lvl=%0d q=%0d",
                                 $time, want.status, want.slot, want.pid, want.level,
                                 want.quantum,
                                 " cnt=%0d actual st=%0d slot=%0d pid=%0h lvl=%0d q=%0d cnt=%0d",
                                 want.count, seen.status, seen.slot, seen.pid,
                                 seen.level, seen.quantum, seen.count);
                    end
                end
            end
            if (!long_done && beats_out >= HOLD_AT) begin
                hold_left = LONG_HOLD;
                long_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (calm) begin
                i_out_stall <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (run_left > 0) begin
                run_left--;
                i_out_stall <= 1'b0;
            end else begin
                stall_left = ($urandom_range(19) == 0) ? $urandom_range(60, 20)
                                                       : $urandom_range(3);
                run_left = $urandom_range(15);
                i_out_stall <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- watchdog
    always @(posedge i_clk) begin : hang_check
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no beat on either channel for %0d cycles", $time, idle_cycles);
                $display("FAIL process_ready_queue_priority_pop_top");
                $finish;
            end
        end
    end

    // -------------------------------------------------------------- sequencing
    initial begin : run_phases
        int   perm [SLOT_COUNT];
        int   i;
        int   j;
        int   t;
        int   k;
        for (i = 0; i < SLOT_COUNT; i++) rq_in[i] = 1'b0;
        for (i = 0; i < 8; i++) kind_seen[i] = 0;
        rq_head  = '0;
        rq_tail  = '0;
        rq_count = '0;
        rq_level = '0;
        pid_pool[0] = '0;
        pid_pool[1] = '1;
        for (i = 2; i < 16; i++) pid_pool[i] = prq_pkg::t_pid'($urandom);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part at the reset level of 0.
        // Every request kind on an empty queue, then the unserved kinds.
        queue_req(prq_pkg::KIND_POP,    6'd0,  31'd0,   4'd0);
        queue_req(prq_pkg::KIND_REMOVE, 6'd0,  31'd0,   4'd0);
        queue_req(prq_pkg::KIND_TOP,    6'd0,  31'd0,   4'd0);
        queue_req(prq_pkg::KIND_ROTATE, 6'd63, 31'd0,   4'd0);
        queue_req(prq_pkg::KIND_EXISTS, 6'd0,  31'd0,   4'd0);
        queue_req(KIND_SPARE_LO,        6'd63, '1,      4'd15);
        queue_req(KIND_SPARE_HI,        6'd0,  31'd0,   4'd0);
        // field extremes; priority 15 is clamped to the top priority of 10
        queue_req(prq_pkg::KIND_PUSH,   6'd0,  31'd0,   4'd0);
        queue_req(prq_pkg::KIND_PUSH,   6'd63, '1,      4'd15);
        queue_req(prq_pkg::KIND_PUSH,   6'd5,  31'd123, 4'd10);
        // push of a queued slot refreshes it in place
        queue_req(prq_pkg::KIND_PUSH,   6'd0,  31'd55,  4'd3);
        queue_req(prq_pkg::KIND_EXISTS, 6'd63, 31'd0,   4'd0);
        queue_req(prq_pkg::KIND_EXISTS, 6'd9,  31'd0,   4'd0);
        queue_req(prq_pkg::KIND_ROTATE, 6'd9,  31'd0,   4'd0);
        queue_req(prq_pkg::KIND_ROTATE, 6'd5,  31'd0,   4'd0);
        queue_req(prq_pkg::KIND_REMOVE, 6'd0,  31'd999, 4'd0);
        queue_req(prq_pkg::KIND_REMOVE, 6'd0,  '1,      4'd0);
        queue_req(prq_pkg::KIND_PUSH,   6'd7,  31'd77,  4'd3);
        // top at the capped priority first, then a tie that the front entry wins
        queue_req(prq_pkg::KIND_TOP,    6'd0,  31'd0,   4'd0);
        queue_req(prq_pkg::KIND_TOP,    6'd0,  31'd0,   4'd0);
        // first pop empties the queue, the second finds it empty, then rebuild from the reset ends
        queue_req(prq_pkg::KIND_POP,    6'd0,  31'd0,   4'd0);
        queue_req(prq_pkg::KIND_POP,    6'd0,  31'd0,   4'd0);
        queue_req(prq_pkg::KIND_PUSH,   6'd1,  31'd42,  4'd9);
        queue_req(prq_pkg::KIND_ROTATE, 6'd1,  31'd0,   4'd0);
        queue_req(prq_pkg::KIND_EXISTS, 6'd1,  31'd0,   4'd0);
        wait_idle();

        set_level(7'd0);
        queue_random(48, 8);
        wait_idle();

        // Special level; fill every slot, some churn, then 30 pops by top priority.
        // The receiver hold-off lands in here, so the request side backs up.
        set_level(prq_pkg::SPECIAL_LEVEL);
        for (i = 0; i < SLOT_COUNT; i++) perm[i] = i;
        for (i = SLOT_COUNT - 1; i > 0; i--) begin
            j = $urandom_range(i);
            t = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
        end
        for (i = 0; i < SLOT_COUNT; i++)
            queue_req(prq_pkg::KIND_PUSH, prq_pkg::t_slot'(perm[i]),
                      pid_pool[$urandom_range(15)], prq_pkg::t_prio'($urandom_range(15)));
        queue_random(20, SLOT_COUNT);
        for (i = 0; i < 30; i++) queue_req(prq_pkg::KIND_TOP, '0, '0, '0);
        wait_idle();

        // levels above the special one, all data bits high; no idling here
        set_level(7'd127);
        calm = 1'b1;
        queue_random(48, 16);
        wait_idle();
        calm = 1'b0;

        set_level(7'd100);
        queue_random(48, 4);
        wait_idle();

        set_level(7'd1);
        queue_random(48, 32);
        wait_idle();

        set_level(7'd98);
        queue_random(48, 8);
        wait_idle();

        set_level(prq_pkg::t_level'($urandom_range(127)));
        queue_random(48, SLOT_COUNT);
        wait_idle();

        repeat (20) @(negedge i_clk);
        k = kind_seen[KIND_SPARE_LO] + kind_seen[KIND_SPARE_HI];
        $display("Covered %0d requests (push %0d, pop %0d, remove %0d, top %0d, rotate %0d,",
                 beats_in, kind_seen[prq_pkg::KIND_PUSH], kind_seen[prq_pkg::KIND_POP],
                 kind_seen[prq_pkg::KIND_REMOVE], kind_seen[prq_pkg::KIND_TOP],
                 kind_seen[prq_pkg::KIND_ROTATE]);
        $display("  exists %0d, unserved %0d), %0d results, peak occupancy %0d, %0d errors",
                 kind_seen[prq_pkg::KIND_EXISTS], k, beats_out, peak_count, errors);
        if (errors == 0) begin
            $display("PASS process_ready_queue_priority_pop_top");
        end else begin
            $display("FAIL process_ready_queue_priority_pop_top");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/prq_pkg.sv
rtl/prq_store.sv
rtl/prq_ctrl.sv
rtl/process_ready_queue_priority_pop_top.sv
dv/process_ready_queue_priority_pop_top_test.sv
